// ----- src/ais_pkg.sv -----
package ais_pkg;

	localparam int unsigned DEPTH = 32;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

endpackage

// ----- src/ais_cell.sv -----
module ais_cell (
	input  logic              clk,
	input  ais_pkg::cell_ctl_t ctl,
	input  logic              occupied,
	input  ais_pkg::data_t    new_value,
	input  logic              prev_lt,
	input  ais_pkg::data_t    prev_value,
	input  ais_pkg::data_t    next_value,
	output logic              lt,
	output ais_pkg::data_t    held
);

	ais_pkg::data_t held_q;

	// An empty cell behaves as if it held plus infinity.
	assign lt = occupied && (held_q <= new_value);
	assign held = held_q;

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			// Cells past the insertion point move one place toward the tail.
			if (!lt) begin
				held_q <= prev_lt ? new_value : prev_value;
			end
		end else if (ctl.shift) begin
			held_q <= next_value;
		end
	end

endmodule

// ----- src/ascending_integer_sorter_unit.sv -----
// Sorted insertion chain of DEPTH cells; each cell compares its word with the incoming one.
// Loading: one word per cycle, no stall while a set is collected.
// Draining: the word that closes a set loads the drain count (rem_q); results then leave
// one per cycle while out_stall allows, head of the chain first, input stalled meanwhile.
// Reset (arst_n low, asynchronous) empties the chain and the output register at once.
module ascending_integer_sorter_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ais_pkg::data_t value,
	input  logic           last_in,
	output logic           out_valid,
	input  logic           out_stall,
	output ais_pkg::data_t sorted_value,
	output logic           last_out,
	output logic           overflow
);

	localparam int unsigned N = ais_pkg::DEPTH;

	ais_pkg::cnt_t count_q;
	ais_pkg::cnt_t rem_q;
	logic overflow_seen_q;
	logic drain_ovf_q;
	logic out_valid_q;
	logic out_last_q;
	logic out_ovf_q;
	ais_pkg::data_t out_value_q;

	logic in_acc;
	logic room;
	logic pop;
	ais_pkg::cell_ctl_t ctl;
	logic [N-1:0] lt;
	logic [N-1:0] occ;
	ais_pkg::data_t held [N];

	assign in_stall = (rem_q != '0);
	assign in_acc = in_valid && !in_stall;
	assign room = (count_q < ais_pkg::cnt_t'(N));
	assign pop = (rem_q != '0) && (!out_valid_q || !out_stall);

	assign ctl.insert = in_acc && room;
	assign ctl.shift = pop;

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign occ[i] = (count_q > ais_pkg::cnt_t'(i));
		ais_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occ[i]),
			.new_value  (value),
			.prev_lt    ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i-1]),
			.prev_value ((i == 0) ? held[0] : held[(i == 0) ? 0 : i-1]),
			.next_value ((i == N-1) ? held[N-1] : held[(i == N-1) ? N-1 : i+1]),
			.lt         (lt[i]),
			.held       (held[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q <= '0;
			overflow_seen_q <= 1'b0;
			drain_ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
			out_ovf_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (last_in) begin
					rem_q <= room ? count_q + ais_pkg::cnt_t'(1) : count_q;
					drain_ovf_q <= overflow_seen_q || !room;
					count_q <= '0;
					overflow_seen_q <= 1'b0;
				end else if (room) begin
					count_q <= count_q + ais_pkg::cnt_t'(1);
				end else begin
					overflow_seen_q <= 1'b1;
				end
			end else if (pop) begin
				rem_q <= rem_q - ais_pkg::cnt_t'(1);
			end
			if (pop) begin
				out_valid_q <= 1'b1;
				out_last_q <= (rem_q == ais_pkg::cnt_t'(1));
				out_ovf_q <= drain_ovf_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_value_q <= held[0];
		end
	end

	assign out_valid = out_valid_q;
	assign sorted_value = out_value_q;
	assign last_out = out_last_q;
	assign overflow = out_ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ais_pkg::cnt_t'(N))
		else $error("element count exceeds chain depth");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= ais_pkg::cnt_t'(N))
		else $error("drain count exceeds chain depth");

	a_close_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_in |=> rem_q != '0)
		else $error("closing word started no drain");

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_out |-> rem_q != '0)
		else $error("word without last flag but nothing left to drain");

endmodule

// ----- sim/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned PHASE_WORDS = 56;
	localparam ais_pkg::data_t MIN_WORD = {1'b1, {(ais_pkg::DATA_W-1){1'b0}}};
	localparam ais_pkg::data_t MAX_WORD = {1'b0, {(ais_pkg::DATA_W-1){1'b1}}};

	typedef struct packed {
		ais_pkg::data_t sorted_value;
		logic           last_out;
		logic           overflow;
	} sorted_word_t;

	typedef struct packed {
		ais_pkg::data_t value;
		logic           last;
		logic           typed;
		sorted_word_t   want;
	} stim_row_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	ais_pkg::data_t value;
	logic           last_in;
	logic           out_valid;
	logic           out_stall = 1'b0;
	ais_pkg::data_t sorted_value;
	logic           last_out;
	logic           overflow;

	ascending_integer_sorter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.last_in      (last_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.overflow     (overflow)
	);

	always #10 clk = ~clk;

	// Model of the chain: held words kept in ascending order as they arrive.
	ais_pkg::data_t held_words[$];
	logic           set_dropped;
	sorted_word_t   sorted_expected[$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned errors;
	int unsigned n_words;
	int unsigned n_sets;
	int unsigned n_overflow_sets;
	int unsigned n_results;
	int unsigned quiet_cycles;

	// Directed words. Single-word sets have their result typed in; the rest go
	// through the model.
	stim_row_t dir_rows[17];

	initial begin
		dir_rows = '{
			'{MIN_WORD,               1'b1, 1'b1, '{MIN_WORD,             1'b1, 1'b0}},
			'{MAX_WORD,               1'b1, 1'b1, '{MAX_WORD,             1'b1, 1'b0}},
			'{ais_pkg::data_t'(0),    1'b1, 1'b1, '{ais_pkg::data_t'(0),  1'b1, 1'b0}},
			'{ais_pkg::data_t'(-1),   1'b1, 1'b1, '{ais_pkg::data_t'(-1), 1'b1, 1'b0}},
			'{MAX_WORD,               1'b0, 1'b0, '0},
			'{MIN_WORD,               1'b0, 1'b0, '0},
			'{ais_pkg::data_t'(0),    1'b0, 1'b0, '0},
			'{ais_pkg::data_t'(-1),   1'b0, 1'b0, '0},
			'{ais_pkg::data_t'(5),    1'b0, 1'b0, '0},
			'{ais_pkg::data_t'(5),    1'b1, 1'b0, '0},
			'{ais_pkg::data_t'(100),  1'b0, 1'b0, '0},
			'{ais_pkg::data_t'(-100), 1'b1, 1'b0, '0},
			'{ais_pkg::data_t'(-7),   1'b0, 1'b0, '0},
			'{ais_pkg::data_t'(7),    1'b1, 1'b0, '0},
			'{ais_pkg::data_t'(42),   1'b0, 1'b0, '0},
			'{ais_pkg::data_t'(42),   1'b0, 1'b0, '0},
			'{ais_pkg::data_t'(42),   1'b1, 1'b0, '0}
		};
	end

	function automatic void sort_insert(input ais_pkg::data_t v, input logic closes,
			ref sorted_word_t fresh[$]);
		int pos;
		int unsigned n;
		sorted_word_t w;
		pos = 0;
		if (held_words.size() < ais_pkg::DEPTH) begin
			while (pos < held_words.size() && held_words[pos] <= v)
				pos++;
			held_words.insert(pos, v);
		end else begin
			set_dropped = 1'b1;
		end
		if (closes) begin
			n = held_words.size();
			for (int unsigned i = 0; i < n; i++) begin
				w = '{held_words[i], (i + 1 == n), set_dropped};
				fresh.insert(fresh.size(), w);
			end
			if (set_dropped)
				n_overflow_sets++;
			n_sets++;
			held_words.delete();
			set_dropped = 1'b0;
		end
	endfunction

	function automatic ais_pkg::data_t rand_word();
		ais_pkg::data_t w;
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0: w = MIN_WORD;
					1: w = MAX_WORD;
					2: w = '0;
					default: w = '1;
				endcase
			end
			1, 2: w = ais_pkg::data_t'(int'($urandom_range(8)) - 4);
			default: w = ais_pkg::data_t'($urandom);
		endcase
		return w;
	endfunction

	task automatic send_word(input ais_pkg::data_t v, input logic closes,
			input logic typed, input sorted_word_t want);
		sorted_word_t fresh[$];
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		last_in <= closes;
		do
			@(posedge clk);
		while (in_stall);
		n_words++;
		sort_insert(v, closes, fresh);
		if (typed)
			sorted_expected.insert(sorted_expected.size(), want);
		else
			foreach (fresh[i])
				sorted_expected.insert(sorted_expected.size(), fresh[i]);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sorted_expected.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		sorted_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (sorted_expected.size() == 0) begin
				$error("unexpected word: sorted_value %0d last_out %0b overflow %0b",
					sorted_value, last_out, overflow);
				errors++;
			end else begin
				want = sorted_expected.pop_front();
				if (sorted_value !== want.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d", want.sorted_value,
						sorted_value);
					errors++;
				end
				if (last_out !== want.last_out) begin
					$error("last_out: expected %0b, got %0b", want.last_out, last_out);
					errors++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, overflow);
					errors++;
				end
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	// Ends the run when neither channel has moved a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("ascending_integer_sorter_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int unsigned phase_words;
		int unsigned len;
		bit first_set;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		value <= '0;
		last_in <= 1'b0;
		set_dropped = 1'b0;
		n_words = 0;
		n_sets = 0;
		n_overflow_sets = 0;
		send_idle_pct = 9;
		recv_stall_pct = 69;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed,
				dir_rows[i].want);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle_pct = 9; recv_stall_pct = 69; end
				1: begin send_idle_pct = 69; recv_stall_pct = 9; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			phase_words = 0;
			first_set = 1'b1;
			while (phase_words < PHASE_WORDS) begin
				// Each phase opens with a set that overruns the chain, the closing
				// word among the dropped ones.
				if (first_set)
					len = ais_pkg::DEPTH + 1 + ph;
				else if ($urandom_range(9) == 0)
					len = $urandom_range(ais_pkg::DEPTH + 4, ais_pkg::DEPTH - 1);
				else
					len = $urandom_range(8, 1);
				first_set = 1'b0;
				for (int unsigned k = 0; k < len; k++) begin
					send_word(rand_word(), (k + 1 == len), 1'b0, '0);
					phase_words++;
				end
			end
			wait_drained();
		end

		repeat (ais_pkg::DEPTH + 8) @(posedge clk);
		$display("Sent %0d words in %0d sets (%0d overflowed) under three idle patterns;",
			n_words, n_sets, n_overflow_sets);
		$display("checked %0d sorted words against the model.", n_results);
		if (errors == 0)
			$display("ascending_integer_sorter_unit regression: pass");
		else
			$display("ascending_integer_sorter_unit regression: fail");
		$finish;
	end

endmodule
